[rtl/wmcd_pkg.sv]
package wmcd_pkg;

	localparam int PIX_W  = 24;
	localparam int MSQ_W  = 18;
	localparam int EDGE_W = 9;
	localparam int SQ_W   = 16;
	localparam int RT_W   = 19;
	localparam int IN_W   = 24;
	localparam int OUT_W  = 32;

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;
	localparam logic       ACT_PIXEL  = 1'b0;

	typedef struct packed {
		logic wr;
		logic scan_init;
		logic scan_step;
		logic sqrt_init;
		logic sqrt_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic due;
		logic scan_last;
		logic sqrt_done;
		logic out_free;
		logic over_lag;
	} sts_t;

endpackage

[rtl/wmcd_ram.sv]
module wmcd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 6144
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[rtl/wmcd_ctl.sv]
module wmcd_ctl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  wmcd_pkg::sts_t sts,
	output wmcd_pkg::cmd_t cmd
);
	import wmcd_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_CHECK = 8'b0000_0010,
		S_CTR   = 8'b0000_0100,
		S_SCAN  = 8'b0000_1000,
		S_F1    = 8'b0001_0000,
		S_F2    = 8'b0010_0000,
		S_SQRT  = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   sqi_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.wr  = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: state_d = sts.due ? S_CTR : S_IDLE;
			S_CTR: begin
				cmd.scan_init = 1'b1;
				state_d       = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) state_d = S_F1;
			end
			S_F1: state_d = S_F2;
			S_F2: state_d = S_SQRT;
			S_SQRT: begin
				if (sqi_q) begin
					cmd.sqrt_init = 1'b1;
				end else if (sts.sqrt_done) begin
					state_d = S_EMIT;
				end else begin
					cmd.sqrt_step = 1'b1;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sqi_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			sqi_q   <= (state_q == S_F2);
		end
	end
endmodule

[rtl/wmcd_dp.sv]
module wmcd_dp #(
	parameter int MAX_WIDTH = 1024,
	parameter int RADIUS    = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [15:0]                cfg_data,
	input  logic [wmcd_pkg::IN_W-1:0]  in_data,
	input  logic                       in_action,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [wmcd_pkg::OUT_W-1:0] out_data,
	output logic                       out_last,
	input  wmcd_pkg::cmd_t             cmd,
	output wmcd_pkg::sts_t             sts
);
	import wmcd_pkg::*;

	localparam int SLOTS = 2 * RADIUS + 2;
	localparam int SW    = $clog2(SLOTS);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int AW    = SW + CW;
	localparam int DEPTH = SLOTS << CW;
	localparam int PW    = $clog2(RADIUS * MAX_WIDTH + RADIUS + 3);
	localparam int KW    = $clog2(2 * RADIUS + 1);
	localparam int TW    = SW + 2;

	logic [10:0]    width_q;
	logic [15:0]    height_q;
	logic [WW-1:0]  w;
	logic [15:0]    h;
	logic [CW-1:0]  in_col_q, out_col_q;
	logic [15:0]    in_row_q, out_row_q;
	logic [SW-1:0]  in_slot_q, out_slot_q;
	logic [PW-1:0]  pending_q, lag;
	logic           frame_in;
	logic [KW-1:0]  dr_q, dc_q;
	logic [16:0]    rr;
	logic [WW:0]    cc;
	logic           win_ok;
	logic [TW-1:0]  t;
	logic [SW-1:0]  win_slot;
	logic [CW-1:0]  win_col;
	logic [AW-1:0]  raddr, waddr;
	logic [PIX_W-1:0] rdata, centre_q;
	logic           valid_s1, centre_s1, valid_s2;
	logic [SQ_W-1:0] sql_s2, sqa_s2, sqb_s2;
	logic [MSQ_W-1:0] sum, best_q;
	logic signed [8:0] dl, da, db;
	logic signed [17:0] pl, pa, pb;
	logic [RT_W-1:0] rem_q, res_q, bit_q;
	logic [RT_W-1:0] trial;
	logic           pix_wr, last;
	logic           out_valid_q;
	logic [MSQ_W-1:0]  msq_q;
	logic [EDGE_W-1:0] edge_q;
	logic           last_q;

	always_comb begin
		if (width_q == 11'd0) w = WW'(1);
		else if (32'(width_q) > MAX_WIDTH) w = WW'(MAX_WIDTH);
		else w = WW'(width_q);
		h = (height_q == 16'd0) ? 16'd1 : height_q;
	end

	assign frame_in = (in_row_q >= h);
	assign lag      = PW'(RADIUS) * PW'(w) + PW'(RADIUS);
	assign pix_wr   = cmd.wr && (in_action == ACT_PIXEL) && !frame_in;
	assign last     = (out_row_q == h - 16'd1) && (WW'(out_col_q) == w - WW'(1));

	assign rr      = 17'(out_row_q) + 17'(dr_q);
	assign cc      = (WW + 1)'(out_col_q) + (WW + 1)'(dc_q);
	assign win_ok  = (rr >= 17'(RADIUS)) && (rr < 17'(h) + 17'(RADIUS))
		&& (cc >= (WW + 1)'(RADIUS)) && (cc < (WW + 1)'(w) + (WW + 1)'(RADIUS));
	assign win_col = CW'(cc - (WW + 1)'(RADIUS));
	assign t       = TW'(out_slot_q) + TW'(dr_q) + TW'(SLOTS - RADIUS);

	always_comb begin
		if (t >= TW'(2 * SLOTS)) win_slot = SW'(t - TW'(2 * SLOTS));
		else if (t >= TW'(SLOTS)) win_slot = SW'(t - TW'(SLOTS));
		else win_slot = SW'(t);
	end

	assign raddr = cmd.scan_init ? {out_slot_q, out_col_q} : {win_slot, win_col};
	assign waddr = {in_slot_q, in_col_q};

	wmcd_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (pix_wr),
		.waddr (waddr),
		.wdata (in_data),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign dl = $signed({1'b0, rdata[7:0]}) - $signed({1'b0, centre_q[7:0]});
	assign da = $signed({rdata[15], rdata[15:8]}) - $signed({centre_q[15], centre_q[15:8]});
	assign db = $signed({rdata[23], rdata[23:16]}) - $signed({centre_q[23], centre_q[23:16]});
	assign pl = dl * dl;
	assign pa = da * da;
	assign pb = db * db;
	assign sum = MSQ_W'(sql_s2) + MSQ_W'(sqa_s2) + MSQ_W'(sqb_s2);
	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= 11'd640;
			height_q    <= 16'd480;
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_slot_q   <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_slot_q  <= '0;
			pending_q   <= '0;
			dr_q        <= '0;
			dc_q        <= '0;
			valid_s1    <= 1'b0;
			centre_s1   <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1  <= cmd.scan_step && win_ok;
			centre_s1 <= cmd.scan_init;
			valid_s2  <= valid_s1;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == REG_WIDTH) width_q <= cfg_data[10:0];
				else height_q <= cfg_data;
				in_col_q   <= '0;
				in_row_q   <= '0;
				in_slot_q  <= '0;
				out_col_q  <= '0;
				out_row_q  <= '0;
				out_slot_q <= '0;
				pending_q  <= '0;
			end else if (pix_wr) begin
				pending_q <= pending_q + PW'(1);
				if (WW'(in_col_q) + WW'(1) >= w) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + 16'd1;
					in_slot_q <= (in_slot_q == SW'(SLOTS - 1)) ? '0 : in_slot_q + SW'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end else if (cmd.emit) begin
				if (last) begin
					in_col_q   <= '0;
					in_row_q   <= '0;
					in_slot_q  <= '0;
					out_col_q  <= '0;
					out_row_q  <= '0;
					out_slot_q <= '0;
					pending_q  <= '0;
				end else begin
					pending_q <= pending_q - PW'(1);
					if (WW'(out_col_q) + WW'(1) >= w) begin
						out_col_q  <= '0;
						out_row_q  <= out_row_q + 16'd1;
						out_slot_q <= (out_slot_q == SW'(SLOTS - 1)) ? '0 : out_slot_q + SW'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
			if (cmd.scan_init) begin
				dr_q <= '0;
				dc_q <= '0;
			end else if (cmd.scan_step) begin
				if (dc_q == KW'(2 * RADIUS)) begin
					dc_q <= '0;
					dr_q <= dr_q + KW'(1);
				end else begin
					dc_q <= dc_q + KW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (centre_s1) centre_q <= rdata;
		sql_s2 <= SQ_W'(pl);
		sqa_s2 <= SQ_W'(pa);
		sqb_s2 <= SQ_W'(pb);
		if (cmd.scan_init) best_q <= '0;
		else if (valid_s2 && sum > best_q) best_q <= sum;
		if (cmd.sqrt_init) begin
			rem_q <= RT_W'(best_q);
			res_q <= '0;
			bit_q <= RT_W'(1) << (RT_W - 1);
		end else if (cmd.sqrt_step) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.emit) begin
			msq_q  <= best_q;
			edge_q <= EDGE_W'(res_q);
			last_q <= last;
		end
	end

	assign sts.due       = frame_in || (pending_q > lag);
	assign sts.scan_last = (dr_q == KW'(2 * RADIUS)) && (dc_q == KW'(2 * RADIUS));
	assign sts.sqrt_done = (bit_q == '0);
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.over_lag  = (pending_q > lag + PW'(1));

	assign out_valid = out_valid_q;
	assign out_data  = {(OUT_W - MSQ_W - EDGE_W)'(0), edge_q, msq_q};
	assign out_last  = last_q;
endmodule

[rtl/window_max_color_distance.sv]
// channel   | signals                              | payload
// s_axis    | tvalid tready tdata[23:0] tuser      | pixel in, tuser = action
// m_axis    | tvalid tready tdata[31:0] tlast      | result out, tlast = frame_end
// cfg       | cfg_we cfg_index cfg_data[15:0]      | 0 image_width, 1 image_height
// An item with no result due passes only the idle and check states; with a result, it also
// runs the one-read-per-cycle window scan of the row store and the 10-step square root unit.
// Reset: counters clear, row store holds garbage until written. A waiting result sits in
// the output register; the next item is taken meanwhile.
module window_max_color_distance #(
	parameter int MAX_WIDTH = 1024,
	parameter int RADIUS    = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // light, green_red, blue_yellow
	input  logic        s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // max_squared[17:0], edge_strength[26:18]
	output logic        m_axis_tlast   // frame_end
);
	import wmcd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	wmcd_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wmcd_dp #(.MAX_WIDTH(MAX_WIDTH), .RADIUS(RADIUS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.in_action (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free) else $error("emit into occupied output");
	a_lag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!sts.over_lag) else $error("pending count beyond lag");
	a_rise_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(cmd.emit)) else $error("result without emit");
endmodule
